/* hdl/abf_pkg.sv */
// ----------------------------------------------------------------------------
// Alpha blit framebuffer package
// Shared widths, command and register codes, the pixel layout and defaults.
// ----------------------------------------------------------------------------
package abf_pkg;

   // Screen size registers and derived products
   localparam int SCR_W  = 9;
   localparam int PROD_W = 2 * SCR_W;

   // Default store geometry
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   // Reset value of both screen size registers
   localparam logic [SCR_W-1:0] SCR_RESET = 9'd256;

   // Command codes
   localparam logic [1:0] CMD_BLIT        = 2'd0;
   localparam logic [1:0] CMD_CLEAR_COLOUR = 2'd1;
   localparam logic [1:0] CMD_CLEAR_LEVEL  = 2'd2;
   localparam logic [1:0] CMD_READ         = 2'd3;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 1'd1;

   // Alpha levels with a special meaning
   localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // One stored pixel: red in the low byte, alpha in the high byte
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

endpackage

/* hdl/abf_chan_if.sv */
// ----------------------------------------------------------------------------
// Alpha blit framebuffer channels
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface abf_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic signed [9:0] origin_x;
   logic signed [9:0] origin_y;
   logic [8:0]        tex_width;
   logic [8:0]        tex_height;
   logic [7:0]        tex_x;
   logic [7:0]        tex_y;
   logic [7:0]        red;
   logic [7:0]        green;
   logic [7:0]        blue;
   logic [7:0]        alpha;

   modport source (output valid, cmd, origin_x, origin_y, tex_width, tex_height,
                   tex_x, tex_y, red, green, blue, alpha, input ready);
   modport sink   (input valid, cmd, origin_x, origin_y, tex_width, tex_height,
                   tex_x, tex_y, red, green, blue, alpha, output ready);
endinterface

interface abf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_red;
   logic [7:0] read_green;
   logic [7:0] read_blue;
   logic [7:0] read_alpha;
   logic       wrote;
   logic       rejected;

   modport source (output valid, read_red, read_green, read_blue, read_alpha,
                   wrote, rejected, input ready);
   modport sink   (input valid, read_red, read_green, read_blue, read_alpha,
                   wrote, rejected, output ready);
endinterface

/* hdl/abf_store.sv */
// ----------------------------------------------------------------------------
// Alpha blit framebuffer pixel store
// Single-port synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module abf_store
   import abf_pkg::*;
#(
   parameter int DEPTH  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  pixel_type         wr_data,
   output pixel_type         rd_data
);

   pixel_type mem_ff [DEPTH];
   pixel_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
   end

   // Read port, data registered and available in the cycle after the request.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/abf_blend.sv */
// ----------------------------------------------------------------------------
// Alpha blit framebuffer blend unit
// Source-over blend of three colour channels, divided by 255 after a register.
// ----------------------------------------------------------------------------
module abf_blend
   import abf_pkg::*;
(
   input  logic      clock,
   input  logic      load,
   input  pixel_type src,
   input  pixel_type dst,
   output pixel_type result
);

   logic [15:0] sum_red_ff;
   logic [15:0] sum_green_ff;
   logic [15:0] sum_blue_ff;
   logic [7:0]  alpha_ff;

   // Weighted sum of source and destination; never exceeds 255 * 255.
   function automatic logic [15:0] weigh(input logic [7:0] s, input logic [7:0] d,
                                         input logic [7:0] a);
      logic [15:0] part_src;
      logic [15:0] part_dst;
      part_src = 16'(s) * 16'(a);
      part_dst = 16'(d) * 16'(ALPHA_OPAQUE - a);
      return part_src + part_dst;
   endfunction

   // Exact floor division by 255 for any value up to 255 * 255.
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

   // Multiplier stage.
   always_ff @(posedge clock) begin
      if (load) begin
         sum_red_ff   <= weigh(src.red, dst.red, src.alpha);
         sum_green_ff <= weigh(src.green, dst.green, src.alpha);
         sum_blue_ff  <= weigh(src.blue, dst.blue, src.alpha);
         alpha_ff     <= src.alpha;
      end
   end

   // Division stage; the blended pixel takes the source alpha.
   always_comb begin
      result.red   = div255(sum_red_ff);
      result.green = div255(sum_green_ff);
      result.blue  = div255(sum_blue_ff);
      result.alpha = alpha_ff;
   end

endmodule

/* hdl/alpha_blit_framebuffer_unit.sv */
// ----------------------------------------------------------------------------
// Alpha blit framebuffer unit
// Framebuffer of 32-bit pixels with source-over texel blits, clears and reads.
// ----------------------------------------------------------------------------
// A rejected or transparent item goes straight to the response, an opaque texel
// is written without a store read, a read and a blended texel read the store
// first, and either clear writes the active screen one pixel per cycle
// through the single store port. One request is handled at a time; the next is
// accepted the cycle after the response is loaded into the output register.
// Reset is synchronous; both screen size registers reset to 256 and the pixel
// store is not cleared.
module alpha_blit_framebuffer_unit
   import abf_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                 clock,
   input  logic                 reset,
   abf_req_if.sink              req_bus,
   abf_rsp_if.source            rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SCR_W-1:0]     csr_wdata
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CALC,
      S_READ,
      S_MIX,
      S_WRITE,
      S_CLEAR,
      S_DONE
   } state_type;

   state_type         state_ff;
   logic [SCR_W-1:0]  scr_width_ff;
   logic [SCR_W-1:0]  scr_height_ff;

   // Captured request
   logic [1:0]        cmd_ff;
   logic signed [9:0] ox_ff;
   logic signed [9:0] oy_ff;
   logic [8:0]        tw_ff;
   logic [8:0]        th_ff;
   logic [7:0]        tx_ff;
   logic [7:0]        ty_ff;
   pixel_type         src_ff;

   // Working registers
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] last_ff;
   pixel_type         res_pix_ff;
   logic              res_wrote_ff;
   logic              res_rej_ff;

   // Output register
   logic              rsp_valid_ff;
   pixel_type         rsp_pix_ff;
   logic              rsp_wrote_ff;
   logic              rsp_rej_ff;

   logic              accept;
   logic [SCR_W-1:0]  act_w;
   logic [SCR_W-1:0]  act_h;
   logic              ox_pos;
   logic              oy_pos;
   logic [9:0]        x_end;
   logic [9:0]        y_end;
   logic              blit_ok;
   logic              read_ok;
   logic              is_clear;
   logic [SCR_W-1:0]  pix_x;
   logic [SCR_W-1:0]  pix_y;
   logic [SCR_W-1:0]  mul_b;
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] addr_sum;
   logic [PROD_W-1:0] last_sum;

   logic              mem_we;
   logic              mem_re;
   pixel_type         mem_wdata;
   pixel_type         mem_rdata;
   pixel_type         fill_pix;
   pixel_type         blend_pix;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         scr_width_ff  <= SCR_RESET;
         scr_height_ff <= SCR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  scr_width_ff  <= csr_wdata;
            CSR_SCREEN_HEIGHT: scr_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Active screen size: zero acts as one, large values clamp to the store.
   always_comb begin
      if (scr_width_ff == '0) begin
         act_w = SCR_W'(1);
      end else if (32'(scr_width_ff) > MAX_WIDTH) begin
         act_w = SCR_W'(MAX_WIDTH);
      end else begin
         act_w = scr_width_ff;
      end
      if (scr_height_ff == '0) begin
         act_h = SCR_W'(1);
      end else if (32'(scr_height_ff) > MAX_HEIGHT) begin
         act_h = SCR_W'(MAX_HEIGHT);
      end else begin
         act_h = scr_height_ff;
      end
   end

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);

   // Capture the request payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff       <= req_bus.cmd;
         ox_ff        <= req_bus.origin_x;
         oy_ff        <= req_bus.origin_y;
         tw_ff        <= req_bus.tex_width;
         th_ff        <= req_bus.tex_height;
         tx_ff        <= req_bus.tex_x;
         ty_ff        <= req_bus.tex_y;
         src_ff.red   <= req_bus.red;
         src_ff.green <= req_bus.green;
         src_ff.blue  <= req_bus.blue;
         src_ff.alpha <= req_bus.alpha;
      end
   end

   // On-screen checks and pixel position.
   always_comb begin
      ox_pos  = !ox_ff[9];
      oy_pos  = !oy_ff[9];
      x_end   = {1'b0, ox_ff[8:0]} + {1'b0, tw_ff};
      y_end   = {1'b0, oy_ff[8:0]} + {1'b0, th_ff};
      blit_ok = ox_pos && oy_pos && (x_end <= {1'b0, act_w}) &&
                (y_end <= {1'b0, act_h}) && ({1'b0, tx_ff} < tw_ff) &&
                ({1'b0, ty_ff} < th_ff);
      read_ok = ox_pos && oy_pos && (ox_ff[8:0] < act_w) && (oy_ff[8:0] < act_h);
      is_clear = (cmd_ff == CMD_CLEAR_COLOUR) || (cmd_ff == CMD_CLEAR_LEVEL);
      if (cmd_ff == CMD_READ) begin
         pix_x = ox_ff[8:0];
         pix_y = oy_ff[8:0];
      end else begin
         pix_x = ox_ff[8:0] + {1'b0, tx_ff};
         pix_y = oy_ff[8:0] + {1'b0, ty_ff};
      end
   end

   // One multiplier serves the row offset and the clear length.
   always_comb begin
      mul_b    = is_clear ? act_h : pix_y;
      prod     = PROD_W'(act_w) * PROD_W'(mul_b);
      addr_sum = prod + PROD_W'(pix_x);
      last_sum = prod - PROD_W'(1);
   end

   // Control sequencer with the result and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         res_wrote_ff <= 1'b0;
         res_rej_ff   <= 1'b0;
      end else begin
         // The output register empties unless a new response is loaded this cycle.
         if (rsp_valid_ff && rsp_bus.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_CALC;
               end
            end
            S_CALC: begin
               res_pix_ff   <= '0;
               res_wrote_ff <= 1'b0;
               res_rej_ff   <= 1'b0;
               if (is_clear) begin
                  addr_ff  <= '0;
                  last_ff  <= ADDR_W'(last_sum);
                  state_ff <= S_CLEAR;
               end else begin
                  addr_ff <= ADDR_W'(addr_sum);
                  if (cmd_ff == CMD_READ) begin
                     res_rej_ff <= !read_ok;
                     state_ff   <= read_ok ? S_READ : S_DONE;
                  end else if (!blit_ok) begin
                     res_rej_ff <= 1'b1;
                     state_ff   <= S_DONE;
                  end else if (src_ff.alpha == ALPHA_CLEAR) begin
                     state_ff <= S_DONE;
                  end else if (src_ff.alpha == ALPHA_OPAQUE) begin
                     state_ff <= S_WRITE;
                  end else begin
                     state_ff <= S_READ;
                  end
               end
            end
            S_READ: begin
               state_ff <= S_MIX;
            end
            S_MIX: begin
               if (cmd_ff == CMD_READ) begin
                  res_pix_ff <= mem_rdata;
                  state_ff   <= S_DONE;
               end else begin
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               res_wrote_ff <= 1'b1;
               state_ff     <= S_DONE;
            end
            S_CLEAR: begin
               if (addr_ff == last_ff) begin
                  res_wrote_ff <= 1'b1;
                  state_ff     <= S_DONE;
               end else begin
                  addr_ff <= addr_ff + ADDR_W'(1);
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_pix_ff   <= res_pix_ff;
                  rsp_wrote_ff <= res_wrote_ff;
                  rsp_rej_ff   <= res_rej_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Store port control and write data selection.
   always_comb begin
      mem_we = (state_ff == S_WRITE) || (state_ff == S_CLEAR);
      mem_re = (state_ff == S_READ);
      if (cmd_ff == CMD_CLEAR_LEVEL) begin
         fill_pix = {4{src_ff.red}};
      end else begin
         fill_pix = src_ff;
      end
      if (state_ff == S_CLEAR) begin
         mem_wdata = fill_pix;
      end else if (src_ff.alpha == ALPHA_OPAQUE) begin
         mem_wdata = src_ff;
      end else begin
         mem_wdata = blend_pix;
      end
   end

   abf_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .rd_en   (mem_re),
      .addr    (addr_ff),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   abf_blend u_blend (
      .clock  (clock),
      .load   (state_ff == S_MIX),
      .src    (src_ff),
      .dst    (mem_rdata),
      .result (blend_pix)
   );

   // Response channel.
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.read_red   = rsp_pix_ff.red;
   assign rsp_bus.read_green = rsp_pix_ff.green;
   assign rsp_bus.read_blue  = rsp_pix_ff.blue;
   assign rsp_bus.read_alpha = rsp_pix_ff.alpha;
   assign rsp_bus.wrote      = rsp_wrote_ff;
   assign rsp_bus.rejected   = rsp_rej_ff;

   // An accepted transaction always starts the address calculation.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_CALC))
      else $error("accepted transaction did not start address calculation");

   // The store is never written while the unit is idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("store written while idle");

   // A response never reports both a write and a rejection.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_wrote_ff && rsp_rej_ff))
      else $error("response both wrote and rejected");

   // A clear sweep never runs past the last active pixel.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (addr_ff <= last_ff))
      else $error("clear sweep ran past the active screen");

endmodule
